// ===== rtl/sbms_pkg.sv =====
// shared types and codes for the shared-buffer multi-stack block
`timescale 1ns / 1ps

package sbms_pkg;

    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_POP  = 2'd1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_BAD   = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        status_t    status;
        logic [5:0] depth;
        logic       empty;
        logic       full;
    } result_t;

endpackage

// ===== rtl/sbms_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module sbms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/sbms_ctrl.sv =====
// stack control: per-stack tops and counts, free list head, read-modify-write sequencer
`timescale 1ns / 1ps

module sbms_ctrl #(
    parameter int NUM_STACKS = 4,
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            action,
    input  logic [1:0]            stack_id,
    input  logic [DATA_WIDTH-1:0] push_data,
    input  logic [2:0]            stacks_in_use,
    input  logic                  res_free,
    output logic                  res_load,
    output sbms_pkg::result_t     res,
    output logic [DATA_WIDTH-1:0] res_data,
    output logic                  data_wr_en,
    output logic [AW-1:0]         data_wr_addr,
    output logic [DATA_WIDTH-1:0] data_wr_data,
    output logic [AW-1:0]         data_rd_addr,
    input  logic [DATA_WIDTH-1:0] data_rd_data,
    output logic                  link_wr_en,
    output logic [AW-1:0]         link_wr_addr,
    output logic [AW-1:0]         link_wr_data,
    output logic [AW-1:0]         link_rd_addr,
    input  logic [AW-1:0]         link_rd_data
);

    import sbms_pkg::*;

    localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    state_t                state_reg, state_next;
    logic [1:0]            act_reg, act_next;
    logic [1:0]            sid_reg, sid_next;
    logic [DATA_WIDTH-1:0] word_reg, word_next;
    logic [AW-1:0]         top_reg [NUM_STACKS];
    logic [AW-1:0]         top_next [NUM_STACKS];
    logic [CW-1:0]         cnt_reg [NUM_STACKS];
    logic [CW-1:0]         cnt_next [NUM_STACKS];
    logic [AW-1:0]         free_head_reg, free_head_next;
    logic [CW-1:0]         free_cnt_reg, free_cnt_next;
    logic [CW-1:0]         fill_reg, fill_next;

    logic [1:0]    cur_act;
    logic [1:0]    cur_sid;
    logic [AW-1:0] cur_top;
    logic [SW-1:0] sidx;
    logic          sid_ok;
    logic [CW-1:0] cnt;
    logic [AW-1:0] top;
    logic          fresh;
    logic [AW-1:0] next_free;
    logic [CW-1:0] depth;

    // read addresses come from the ports while idle, from the held beat otherwise
    always_comb
    begin
        cur_act      = (state_reg == S_IDLE) ? action : act_reg;
        cur_sid      = (state_reg == S_IDLE) ? stack_id : sid_reg;
        cur_top      = top_reg[SW'(cur_sid)];
        data_rd_addr = cur_top;
        link_rd_addr = (cur_act == ACT_PUSH) ? free_head_reg : cur_top;
    end

    always_comb
    begin
        sidx   = SW'(sid_reg);
        sid_ok = (3'(sid_reg) < stacks_in_use) && (5'(sid_reg) < 5'(NUM_STACKS));
        cnt    = cnt_reg[sidx];
        top    = top_reg[sidx];
        // slots at or above the fill mark were never linked: link is slot plus one
        fresh  = (CW'(free_head_reg) >= fill_reg);
        if (fresh)
        begin
            next_free = (free_head_reg == AW'(CAPACITY - 1)) ? '0 : free_head_reg + 1'b1;
        end
        else
        begin
            next_free = link_rd_data;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        sid_next       = sid_reg;
        word_next      = word_reg;
        top_next       = top_reg;
        cnt_next       = cnt_reg;
        free_head_next = free_head_reg;
        free_cnt_next  = free_cnt_reg;
        fill_next      = fill_reg;
        in_ready       = 1'b0;
        res_load       = 1'b0;
        res_data       = '0;
        depth          = '0;
        res.status     = STAT_OK;
        data_wr_en     = 1'b0;
        data_wr_addr   = free_head_reg;
        data_wr_data   = word_reg;
        link_wr_en     = 1'b0;
        link_wr_addr   = free_head_reg;
        link_wr_data   = top;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    act_next   = action;
                    sid_next   = stack_id;
                    word_next  = push_data;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (res_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                    if (!sid_ok)
                    begin
                        res.status = STAT_BAD;
                    end
                    else if (act_reg == ACT_PUSH)
                    begin
                        depth = cnt;
                        if (free_cnt_reg == '0)
                        begin
                            res.status = STAT_FULL;
                        end
                        else
                        begin
                            data_wr_en     = 1'b1;
                            link_wr_en     = 1'b1;
                            free_head_next = next_free;
                            top_next[sidx] = free_head_reg;
                            cnt_next[sidx] = cnt + 1'b1;
                            free_cnt_next  = free_cnt_reg - 1'b1;
                            depth          = cnt + 1'b1;
                            if (fresh)
                            begin
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                    end
                    else if (cnt == '0)
                    begin
                        res.status = STAT_EMPTY;
                    end
                    else
                    begin
                        res_data = data_rd_data;
                        depth    = cnt;
                        if (act_reg == ACT_POP)
                        begin
                            link_wr_en     = 1'b1;
                            link_wr_addr   = top;
                            link_wr_data   = free_head_reg;
                            free_head_next = top;
                            top_next[sidx] = link_rd_data;
                            cnt_next[sidx] = cnt - 1'b1;
                            free_cnt_next  = free_cnt_reg + 1'b1;
                            depth          = cnt - 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        res.depth = 6'(depth);
        res.empty = (depth == '0);
        res.full  = (free_cnt_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            free_cnt_reg  <= CW'(CAPACITY);
            fill_reg      <= '0;
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            free_cnt_reg  <= free_cnt_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        sid_reg  <= sid_next;
        word_reg <= word_next;
        top_reg  <= top_next;
    end

`ifndef NO_ASSERTIONS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("beat accepted while another is in flight");

    a_result_frees: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (state_reg == S_IDLE))
        else $error("sequencer did not return to idle after result");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (data_wr_en) |-> (free_cnt_reg != '0))
        else $error("push wrote a slot with no free slot left");

    a_fill_covers_used: assert property (@(posedge clk) disable iff (!rst_n)
        ((CW + 1)'(fill_reg) + (CW + 1)'(free_cnt_reg)) >= (CW + 1)'(CAPACITY))
        else $error("fill mark below number of slots in use");
`endif

endmodule

// ===== rtl/shared_buffer_multi_stack_top.sv =====
// top level: config register, data and link memories, stack control, result register
`timescale 1ns / 1ps

// Several LIFO stacks share one data memory of CAPACITY words; a link memory
// chains each stack and the free list. The accept cycle launches the read of
// the data and link memories; the execute state then uses the registered read
// data, writes back what the action needs (data and link on a push, link on a
// pop) and loads the result register, waiting while the last result is unread.
// The next beat is accepted in the cycle after that, so no beat is taken before
// the last one has loaded its result. No clearing pass runs after reset: a fill
// mark stands in for the initial chaining of the link memory.
module shared_buffer_multi_stack_top #(
    parameter int NUM_STACKS = 4,
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            action,
    input  logic [1:0]            stack_id,
    input  logic [DATA_WIDTH-1:0] push_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] read_data,
    output logic [1:0]            status,
    output logic [5:0]            stack_depth,
    output logic                  stack_empty,
    output logic                  memory_full
);

    import sbms_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [2:0]            stacks_in_use_reg;
    logic                  out_valid_reg;
    result_t               res_reg;
    logic [DATA_WIDTH-1:0] read_data_reg;

    logic                  res_free;
    logic                  res_load;
    result_t               res;
    logic [DATA_WIDTH-1:0] res_data;

    logic                  data_wr_en;
    logic [AW-1:0]         data_wr_addr;
    logic [DATA_WIDTH-1:0] data_wr_data;
    logic [AW-1:0]         data_rd_addr;
    logic [DATA_WIDTH-1:0] data_rd_data;
    logic                  link_wr_en;
    logic [AW-1:0]         link_wr_addr;
    logic [AW-1:0]         link_wr_data;
    logic [AW-1:0]         link_rd_addr;
    logic [AW-1:0]         link_rd_data;

    assign res_free = !out_valid_reg || out_ready;

    sbms_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (data_wr_en),
        .wr_addr (data_wr_addr),
        .wr_data (data_wr_data),
        .rd_addr (data_rd_addr),
        .rd_data (data_rd_data)
    );

    sbms_ram #(
        .WIDTH (AW),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data)
    );

    sbms_ctrl #(
        .NUM_STACKS (NUM_STACKS),
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .stack_id      (stack_id),
        .push_data     (push_data),
        .stacks_in_use (stacks_in_use_reg),
        .res_free      (res_free),
        .res_load      (res_load),
        .res           (res),
        .res_data      (res_data),
        .data_wr_en    (data_wr_en),
        .data_wr_addr  (data_wr_addr),
        .data_wr_data  (data_wr_data),
        .data_rd_addr  (data_rd_addr),
        .data_rd_data  (data_rd_data),
        .link_wr_en    (link_wr_en),
        .link_wr_addr  (link_wr_addr),
        .link_wr_data  (link_wr_data),
        .link_rd_addr  (link_rd_addr),
        .link_rd_data  (link_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stacks_in_use_reg <= 3'd4;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                stacks_in_use_reg <= cfg_wr_data;
            end
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg       <= res;
            read_data_reg <= res_data;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = read_data_reg;
    assign status      = res_reg.status;
    assign stack_depth = res_reg.depth;
    assign stack_empty = res_reg.empty;
    assign memory_full = res_reg.full;

endmodule

// ===== bench/tb_shared_buffer_multi_stack_top.sv =====
// testbench for the shared-buffer multi-stack block: predicted stack operations checked beat by beat
`timescale 1ns / 1ps

module tb_shared_buffer_multi_stack_top;
    import sbms_pkg::*;

    localparam int NUM_STACKS = 4;
    localparam int CAPACITY   = 32;
    localparam int DATA_WIDTH = 32;

    localparam logic [1:0] ACT_PEEK    = 2'd2;
    localparam logic [1:0] ACT_PEEK_HI = 2'd3;

    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct {
        logic [1:0]  act;
        logic [1:0]  sid;
        logic [31:0] word;
    } stack_op_t;

    typedef struct {
        logic [31:0] rd;
        status_t     st;
        logic [5:0]  depth;
        logic        empty;
        logic        full;
    } stack_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_wr_data = 3'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  action = 2'd0;
    logic [1:0]  stack_id = 2'd0;
    logic [31:0] push_data = 32'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] read_data;
    logic [1:0]  status;
    logic [5:0]  stack_depth;
    logic        stack_empty;
    logic        memory_full;

    // predictor state
    logic [31:0] slot_word [CAPACITY];
    logic [4:0]  slot_link [CAPACITY];
    logic [4:0]  stack_top [NUM_STACKS];
    logic [5:0]  stack_len [NUM_STACKS];
    logic [4:0]  free_ptr;
    logic [5:0]  free_len;
    logic [2:0]  enabled_stacks;

    stack_op_t     pending_ops[$];
    stack_result_t expected_results[$];

    int err_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int setting_count = 0;
    int status_hits [4] = '{0, 0, 0, 0};

    // sender and receiver shaping
    int   burst_left = 0;
    int   gap_left = 0;
    bit   gaps_on = 1'b0;
    int   rx_mode = 0;
    int   rx_tick = 0;
    int   hold_left = 0;
    logic hold_off_req = 1'b0;

    shared_buffer_multi_stack_top #(
        .NUM_STACKS (NUM_STACKS),
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .stack_id    (stack_id),
        .push_data   (push_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_data   (read_data),
        .status      (status),
        .stack_depth (stack_depth),
        .stack_empty (stack_empty),
        .memory_full (memory_full)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic stack_result_t predict_stack_op(input stack_op_t op);
        stack_result_t r;
        logic [4:0]    slot;
        int            lim;
        r.rd    = '0;
        r.st    = STAT_OK;
        r.depth = '0;
        lim = (enabled_stacks < NUM_STACKS) ? int'(enabled_stacks) : NUM_STACKS;
        if (int'(op.sid) >= lim)
        begin
            r.st = STAT_BAD;
        end
        else if (op.act == ACT_PUSH)
        begin
            if (free_len == 0)
            begin
                r.st = STAT_FULL;
            end
            else
            begin
                slot = free_ptr;
                free_ptr = slot_link[slot];
                slot_link[slot] = stack_top[op.sid];
                stack_top[op.sid] = slot;
                slot_word[slot] = op.word;
                stack_len[op.sid] = stack_len[op.sid] + 6'd1;
                free_len = free_len - 6'd1;
            end
            r.depth = stack_len[op.sid];
        end
        else if (stack_len[op.sid] == 0)
        begin
            r.st = STAT_EMPTY;
        end
        else
        begin
            slot = stack_top[op.sid];
            r.rd = slot_word[slot];
            if (op.act == ACT_POP)
            begin
                stack_top[op.sid] = slot_link[slot];
                slot_link[slot] = free_ptr;
                free_ptr = slot;
                stack_len[op.sid] = stack_len[op.sid] - 6'd1;
                free_len = free_len + 6'd1;
            end
            r.depth = stack_len[op.sid];
        end
        r.empty = (r.depth == 0);
        r.full  = (free_len == 0);
        return r;
    endfunction

    function automatic stack_op_t make_op(input logic [1:0] act, input logic [1:0] sid,
                                          input logic [31:0] word);
        stack_op_t op;
        op.act  = act;
        op.sid  = sid;
        op.word = word;
        return op;
    endfunction

    function automatic stack_op_t random_op(input int push_pct);
        stack_op_t op;
        int        pick;
        int        lim;
        lim = (enabled_stacks < NUM_STACKS) ? int'(enabled_stacks) : NUM_STACKS;
        pick = $urandom_range(0, 99);
        if (pick < push_pct)
            op.act = ACT_PUSH;
        else
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                op.act = ACT_POP;
            else if (pick < 8)
                op.act = ACT_PEEK;
            else
                op.act = ACT_PEEK_HI;
        end
        if (lim > 0 && $urandom_range(0, 9) != 0)
            op.sid = 2'($urandom_range(0, lim - 1));
        else
            op.sid = 2'($urandom_range(0, 3));
        op.word = $urandom();
        return op;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            err_count++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
        end
    endtask

    task automatic write_stacks_in_use(input logic [2:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        enabled_stacks = value;
        setting_count++;
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || expected_results.size() != 0 || in_valid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            action    <= 2'd0;
            stack_id  <= 2'd0;
            push_data <= 32'd0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(predict_stack_op(pending_ops[0]));
                status_hits[expected_results[$].st]++;
                pending_ops.delete(0);
                sent_count++;
            end
            if (!(in_valid && !in_ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_ops.size() != 0)
                begin
                    in_valid  <= 1'b1;
                    action    <= pending_ops[0].act;
                    stack_id  <= pending_ops[0].sid;
                    push_data <= pending_ops[0].word;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = gaps_on ? $urandom_range(0, 5) : 0;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            rx_tick++;
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    2: out_ready <= ((rx_tick % 7) < 4);
                    default: out_ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                err_count++;
                $display("%0t: result beat with nothing expected, actual data %h status %0d",
                         $time, read_data, status);
            end
            else
            begin
                check_field("read_data", expected_results[0].rd, read_data);
                check_field("status", 32'(expected_results[0].st), 32'(status));
                check_field("stack_depth", 32'(expected_results[0].depth), 32'(stack_depth));
                check_field("stack_empty", 32'(expected_results[0].empty), 32'(stack_empty));
                check_field("memory_full", 32'(expected_results[0].full), 32'(memory_full));
                expected_results.delete(0);
                checked_count++;
            end
        end
    end

    initial
    begin
        #(20_000_000);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [2:0] phase_setting [12];
        int         phase_push [12];
        int         n_items;

        phase_setting = '{3'd4, 3'd1, 3'd7, 3'd3, 3'd2, 3'd4,
                          3'd5, 3'd0, 3'd4, 3'd6, 3'd4, 3'd1};
        phase_push = '{60, 85, 90, 30, 50, 15, 55, 50, 80, 20, 50, 40};

        for (int i = 0; i < CAPACITY; i++)
        begin
            slot_word[i] = '0;
            slot_link[i] = 5'(i + 1);
        end
        for (int s = 0; s < NUM_STACKS; s++)
        begin
            stack_top[s] = '0;
            stack_len[s] = '0;
        end
        free_ptr = '0;
        free_len = 6'(CAPACITY);
        enabled_stacks = 3'd4;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty stacks, data extremes, peek both encodings, lifo order
        gaps_on = 1'b0;
        rx_mode = 0;
        write_stacks_in_use(3'd4);
        pending_ops.push_back(make_op(ACT_PEEK, 2'd0, 32'h0));
        pending_ops.push_back(make_op(ACT_POP, 2'd0, 32'hffff_ffff));
        pending_ops.push_back(make_op(ACT_PEEK_HI, 2'd1, 32'h0));
        pending_ops.push_back(make_op(ACT_PUSH, 2'd0, 32'hffff_ffff));
        pending_ops.push_back(make_op(ACT_PUSH, 2'd3, 32'h0000_0000));
        pending_ops.push_back(make_op(ACT_PUSH, 2'd0, 32'ha5a5_5a5a));
        pending_ops.push_back(make_op(ACT_PEEK, 2'd0, 32'h0));
        pending_ops.push_back(make_op(ACT_PEEK_HI, 2'd0, 32'h0));
        pending_ops.push_back(make_op(ACT_POP, 2'd0, 32'h0));
        pending_ops.push_back(make_op(ACT_POP, 2'd0, 32'h0));
        pending_ops.push_back(make_op(ACT_POP, 2'd0, 32'h0));
        pending_ops.push_back(make_op(ACT_POP, 2'd3, 32'h0));
        pending_ops.push_back(make_op(ACT_PUSH, 2'd1, 32'h1234_5678));
        pending_ops.push_back(make_op(ACT_PUSH, 2'd2, 32'h8765_4321));
        pending_ops.push_back(make_op(ACT_POP, 2'd2, 32'h0));
        wait_drained();

        // directed: bad stack ids under a narrow and a zero setting, then valid ids under an oversized setting
        write_stacks_in_use(3'd2);
        pending_ops.push_back(make_op(ACT_PUSH, 2'd2, 32'hdead_beef));
        pending_ops.push_back(make_op(ACT_POP, 2'd3, 32'h0));
        pending_ops.push_back(make_op(ACT_PEEK_HI, 2'd3, 32'h0));
        pending_ops.push_back(make_op(ACT_PEEK, 2'd1, 32'h0));
        wait_drained();
        write_stacks_in_use(3'd0);
        pending_ops.push_back(make_op(ACT_PUSH, 2'd0, 32'h5555_aaaa));
        pending_ops.push_back(make_op(ACT_POP, 2'd1, 32'h0));
        wait_drained();
        write_stacks_in_use(3'd7);
        pending_ops.push_back(make_op(ACT_PUSH, 2'd3, 32'h0f0f_f0f0));
        pending_ops.push_back(make_op(ACT_POP, 2'd3, 32'h0));
        pending_ops.push_back(make_op(ACT_POP, 2'd1, 32'h0));
        wait_drained();

        // random phases with fill, drain and mixed traffic
        for (int p = 0; p < 12; p++)
        begin
            write_stacks_in_use(phase_setting[p]);
            gaps_on = (p % 3 != 0);
            rx_mode = (p % 3 == 0) ? 0 : $urandom_range(1, 3);
            if (p == 2)
                hold_off_req = 1'b1;
            n_items = (phase_setting[p] == 3'd0) ? 40 : 170;
            for (int k = 0; k < n_items; k++)
                pending_ops.push_back(random_op(phase_push[p]));
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            err_count++;
            $display("%0t: %0d results never arrived", $time, expected_results.size());
        end
        $display("tb: %0d stack ops over %0d register settings, %0d results checked",
                 sent_count, setting_count, checked_count);
        $display("tb: status mix ok %0d, full %0d, empty %0d, bad id %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sbms_pkg.sv
rtl/sbms_ram.sv
rtl/sbms_ctrl.sv
rtl/shared_buffer_multi_stack_top.sv
bench/tb_shared_buffer_multi_stack_top.sv
